// ----- rtl/core/sbmq_pkg.sv -----
`timescale 1ns / 1ps

package sbmq_pkg;

	localparam int DEF_STORE_DEPTH = 16;
	localparam int DEF_NUM_QUEUES  = 4;
	localparam int DEF_DATA_WIDTH  = 32;

	typedef enum logic [0:0] {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		SQ_IDLE  = 1'b0,
		SQ_WRITE = 1'b1
	} seq_state_t;

	typedef struct packed {
		logic               mode;
		logic [1:0]         queue_id;
		logic signed [31:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		status_t            status;
	} rsp_t;

	// qsel is already wrapped into the queue range
	typedef struct packed {
		op_t         op;
		logic [1:0]  qsel;
		logic [31:0] word;
	} cmd_t;

endpackage

// ----- rtl/core/sbmq_front.sv -----
`timescale 1ns / 1ps

module sbmq_front import sbmq_pkg::*; #(
	parameter int NUM_QUEUES = DEF_NUM_QUEUES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic cmd_valid,
	input  logic cmd_pop,
	output cmd_t cmd
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cmd_in;

	// id wraps modulo the queue count; id is below 4 so three subtract steps suffice
	function automatic logic [1:0] wrap_queue(input logic [1:0] id);
		logic [1:0] v;
		v = id;
		for (int i = 0; i < 3; i++) begin
			if (32'(v) >= NUM_QUEUES) begin
				v = v - 2'(NUM_QUEUES);
			end
		end
		return v;
	endfunction

	always_comb begin
		cmd_in.op   = req.mode ? OP_DEQ : OP_ENQ;
		cmd_in.qsel = wrap_queue(req.queue_id);
		cmd_in.word = req.data_in;
	end

	assign req_stall = (count_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// ----- rtl/core/sbmq_back.sv -----
`timescale 1ns / 1ps

module sbmq_back import sbmq_pkg::*; #(
	parameter int STORE_DEPTH = DEF_STORE_DEPTH,
	parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
	parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_pop,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int LW = $clog2(STORE_DEPTH + 1);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int CW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam logic [LW-1:0] LINK_NULL = LW'(STORE_DEPTH);

	seq_state_t state_q, state_d;

	logic [LW-1:0]         free_head_q;
	logic [LW-1:0]         fresh_q;
	logic [LW-1:0]         head_q [NUM_QUEUES];
	logic [LW-1:0]         tail_q [NUM_QUEUES];
	logic [LW-1:0]         link_mem [STORE_DEPTH];
	logic [DATA_WIDTH-1:0] data_mem [STORE_DEPTH];
	logic [LW-1:0]         link_rd_q;
	logic [DATA_WIDTH-1:0] data_rd_q;
	cmd_t                  cmd_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic          out_free;
	logic          commit;
	logic [QW-1:0] qi_in;
	logic [LW-1:0] rd_addr;
	logic          rd_en;
	logic [QW-1:0] qi;
	logic [LW-1:0] cur_head;
	logic [LW-1:0] cur_tail;
	logic          enq_ok;
	logic          deq_ok;
	logic          slot_fresh;
	logic          link_we;
	logic [AW-1:0] link_wa;
	logic [LW-1:0] link_wd;
	logic          data_we;
	rsp_t          rsp_d;

	assign out_free = !rsp_valid_q || !rsp_stall;

	// sequencer: idle pops and reads the link store, write commits
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (cmd_valid) begin
					state_d = SQ_WRITE;
				end
			end
			SQ_WRITE: begin
				if (out_free) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		commit  = 1'b0;
		case (state_q)
			SQ_IDLE:  cmd_pop = cmd_valid;
			SQ_WRITE: commit  = out_free;
			default: begin
				cmd_pop = 1'b0;
				commit  = 1'b0;
			end
		endcase
	end

	// read address: queue head for dequeue, free-list head for enqueue
	always_comb begin
		qi_in   = QW'(cmd.qsel);
		rd_addr = (cmd.op == OP_DEQ) ? head_q[qi_in] : free_head_q;
		rd_en   = cmd_pop && (rd_addr < LINK_NULL);
	end

	always_comb begin
		qi         = QW'(cmd_q.qsel);
		cur_head   = head_q[qi];
		cur_tail   = tail_q[qi];
		enq_ok     = (cmd_q.op == OP_ENQ) && (free_head_q < LINK_NULL);
		deq_ok     = (cmd_q.op == OP_DEQ) && (cur_head < LINK_NULL);
		// entries at or above the fill count were never handed out; their link is index+1
		slot_fresh = (free_head_q == fresh_q);

		link_we = 1'b0;
		link_wa = cur_head[AW-1:0];
		link_wd = free_head_q;
		if (commit && enq_ok && (cur_head < LINK_NULL)) begin
			link_we = 1'b1;
			link_wa = cur_tail[AW-1:0];
		end else if (commit && deq_ok) begin
			link_we = 1'b1;
		end
		data_we = commit && enq_ok;

		rsp_d.data_out = deq_ok ? 32'(data_rd_q[CW-1:0]) : 32'sd0;
		if (cmd_q.op == OP_ENQ) begin
			rsp_d.status = enq_ok ? ST_OK : ST_FULL;
		end else begin
			rsp_d.status = deq_ok ? ST_OK : ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			free_head_q <= '0;
			fresh_q     <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= LINK_NULL;
				tail_q[i] <= LINK_NULL;
			end
		end else begin
			state_q <= state_d;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (commit && enq_ok) begin
				if (slot_fresh) begin
					free_head_q <= fresh_q + 1'b1;
					fresh_q     <= fresh_q + 1'b1;
				end else begin
					free_head_q <= link_rd_q;
				end
				if (!(cur_head < LINK_NULL)) begin
					head_q[qi] <= free_head_q;
				end
				tail_q[qi] <= free_head_q;
			end else if (commit && deq_ok) begin
				// the tail's link is never kept up to date, so compare against tail
				if (cur_head == cur_tail) begin
					head_q[qi] <= LINK_NULL;
					tail_q[qi] <= LINK_NULL;
				end else begin
					head_q[qi] <= link_rd_q;
				end
				free_head_q <= cur_head;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (rd_en) begin
			link_rd_q <= link_mem[rd_addr[AW-1:0]];
			data_rd_q <= data_mem[rd_addr[AW-1:0]];
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (data_we) begin
			data_mem[free_head_q[AW-1:0]] <= DATA_WIDTH'(cmd_q.word[CW-1:0]);
		end
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/shared_buffer_multi_queue.sv -----
`timescale 1ns / 1ps
// A transaction passes the front FIFO, then the back end's idle state (pop, store read)
// and write state (pointer/link write-back, result register). The back end takes the next
//   one only after that write-back; a stalled earlier result holds the write state.
// Front holds up to 2 transactions; result register lets the next one in while waiting.
// Reset: all queues empty, free list rebuilt lazily by a fill count (no clearing pass).

module shared_buffer_multi_queue import sbmq_pkg::*; #(
	parameter int STORE_DEPTH = DEF_STORE_DEPTH,
	parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
	parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	sbmq_front #(
		.NUM_QUEUES(NUM_QUEUES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	sbmq_back #(
		.STORE_DEPTH(STORE_DEPTH),
		.NUM_QUEUES (NUM_QUEUES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/core/sbmq_chk.sv -----
`timescale 1ns / 1ps

module sbmq_chk import sbmq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> (rsp.data_out == 32'sd0))
		else $error("failed transaction carries nonzero data");

	a_reset_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !req_stall && !rsp_valid)
		else $error("block not empty after reset");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(req_stall) |-> $past(req_valid && !req_stall))
		else $error("input stall rose without an accepted transaction");

endmodule

bind shared_buffer_multi_queue sbmq_chk u_chk (.*);

// ----- tb/sv/shared_buffer_multi_queue_test.sv -----
`timescale 1ns / 1ps

module shared_buffer_multi_queue_test;
	import sbmq_pkg::*;

	localparam int DEPTH = DEF_STORE_DEPTH;
	localparam int QUEUES = DEF_NUM_QUEUES;
	localparam int PW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] NIL = PW'(DEPTH);
	localparam int SEGMENT_LEN = 60;
	localparam int NUM_SEGMENTS = 28;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	shared_buffer_multi_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// predicted queue state; NIL marks an empty link
	logic [PW-1:0] free_ptr;
	logic [PW-1:0] head_ptr [QUEUES];
	logic [PW-1:0] tail_ptr [QUEUES];
	logic [PW-1:0] link_ptr [DEPTH];
	logic [31:0] word_mem [DEPTH];

	rsp_t pending_rsp [$];
	bit quiet = 1'b0;
	int mismatches = 0;
	int unexpected = 0;
	int checked = 0;
	int n_enq = 0;
	int n_full = 0;
	int n_deq = 0;
	int n_empty = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d results still outstanding", pending_rsp.size());
		$display("simulation failed");
		$finish;
	end

	function automatic void reset_queue_state();
		free_ptr = '0;
		for (int q = 0; q < QUEUES; q++) begin
			head_ptr[q] = NIL;
			tail_ptr[q] = NIL;
		end
		for (int i = 0; i < DEPTH; i++) begin
			link_ptr[i] = PW'(i + 1);
			word_mem[i] = '0;
		end
	endfunction

	function automatic rsp_t predict_queue_op(req_t item);
		int unsigned q;
		logic [PW-1:0] slot;
		rsp_t r;
		q = item.queue_id % QUEUES;
		r.data_out = '0;
		r.status = ST_OK;
		if (op_t'(item.mode) == OP_ENQ) begin
			slot = free_ptr;
			if (slot >= DEPTH) begin
				r.status = ST_FULL;
				n_full++;
			end else begin
				free_ptr = link_ptr[slot];
				if (head_ptr[q] >= DEPTH || tail_ptr[q] >= DEPTH)
					head_ptr[q] = slot;
				else
					link_ptr[tail_ptr[q]] = slot;
				link_ptr[slot] = NIL;
				tail_ptr[q] = slot;
				word_mem[slot] = item.data_in;
				n_enq++;
			end
		end else begin
			slot = head_ptr[q];
			if (slot >= DEPTH) begin
				r.status = ST_EMPTY;
				n_empty++;
			end else begin
				head_ptr[q] = link_ptr[slot];
				// last entry gone: tail goes null too
				if (head_ptr[q] >= DEPTH) begin
					head_ptr[q] = NIL;
					tail_ptr[q] = NIL;
				end
				link_ptr[slot] = free_ptr;
				free_ptr = slot;
				r.data_out = word_mem[slot];
				n_deq++;
			end
		end
		return r;
	endfunction

	task automatic send_op(input op_t op, input logic [1:0] qid, input logic [31:0] word);
		req_t item;
		item.mode = op;
		item.queue_id = qid;
		item.data_in = word;
		while (!quiet && $urandom_range(99) < 12) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(predict_queue_op(item));
	endtask

	always @(posedge clk) begin : rsp_monitor
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("unexpected result: data %h status %0d", rsp.data_out, rsp.status);
			end else begin
				want = pending_rsp.pop_front();
				checked++;
				if (rsp.data_out !== want.data_out || rsp.status !== want.status) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("result %0d: expected data %h status %s, got data %h status %0d",
							checked, want.data_out, want.status.name(), rsp.data_out,
							rsp.status);
				end
			end
		end
		rsp_stall <= !quiet && ($urandom_range(99) < 12);
	end

	task automatic test_extremes_per_queue();
		send_op(OP_DEQ, 2'd0, $urandom());
		send_op(OP_ENQ, 2'd0, 32'h7fff_ffff);
		send_op(OP_ENQ, 2'd1, 32'h8000_0000);
		send_op(OP_ENQ, 2'd2, 32'h0000_0000);
		send_op(OP_ENQ, 2'd3, 32'hffff_ffff);
	endtask

	task automatic test_queue_emptied();
		// q0 holds one word: drain it, reuse it, then hit empty again
		send_op(OP_DEQ, 2'd0, $urandom());
		send_op(OP_ENQ, 2'd0, 32'h5a5a_a5a5);
		send_op(OP_DEQ, 2'd0, '0);
		send_op(OP_DEQ, 2'd0, '1);
	endtask

	task automatic test_store_full();
		while (free_ptr < DEPTH)
			send_op(OP_ENQ, 2'd1, $urandom());
		send_op(OP_ENQ, 2'd2, $urandom());
		send_op(OP_DEQ, 2'd1, $urandom());
		send_op(OP_DEQ, 2'd3, $urandom());
	endtask

	task automatic test_random_traffic();
		int enq_pct;
		int focus_q;
		logic [1:0] qid;
		logic [31:0] word;
		for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
			case (seg % 5)
				0: enq_pct = 90;
				1: enq_pct = 50;
				2: enq_pct = 15;
				3: enq_pct = 65;
				default: enq_pct = 35;
			endcase
			focus_q = (seg % 3 == 0) ? int'($urandom_range(QUEUES - 1)) : -1;
			quiet = (seg == 7 || seg == 8);
			for (int i = 0; i < SEGMENT_LEN; i++) begin
				if (focus_q >= 0 && $urandom_range(99) < 75)
					qid = 2'(focus_q);
				else
					qid = 2'($urandom_range(3));
				case ($urandom_range(15))
					0: word = 32'h8000_0000;
					1: word = 32'h7fff_ffff;
					2: word = '0;
					3: word = '1;
					default: word = $urandom();
				endcase
				send_op(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ, qid, word);
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		reset_queue_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes_per_queue();
		test_queue_emptied();
		test_store_full();
		test_random_traffic();

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d enqueues, %0d store-full rejects, %0d dequeues, %0d empty dequeues",
			n_enq, n_full, n_deq, n_empty);
		$display("%0d results checked, %0d mismatches, %0d unexpected results",
			checked, mismatches, unexpected);
		if (mismatches == 0 && unexpected == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- shared_buffer_multi_queue.f -----
rtl/core/sbmq_pkg.sv
rtl/core/sbmq_front.sv
rtl/core/sbmq_back.sv
rtl/core/shared_buffer_multi_queue.sv
rtl/core/sbmq_chk.sv
tb/sv/shared_buffer_multi_queue_test.sv
